@@ hdl/chp_pkg.sv @@
// Shared types and constants for the circular harmonic projection block.
// Holds the controller state encoding, the command struct and the sine table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

    localparam int SAMPLE_W = 24;
    localparam int WARP_W   = 18;
    localparam int COMP_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int ACC_W    = 48;
    localparam int COEF_W   = 18;
    localparam int NUM_ACC  = 15;
    localparam int ORDER_W  = 3;
    localparam int CCOUNT_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_ORDER = 2'd1;

    localparam logic [16:0] Q16_ONE      = 17'd65536;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_PREP   = 9'b000000010,
        ST_DIV    = 9'b000000100,
        ST_PHASE  = 9'b000001000,
        ST_COEF_A = 9'b000010000,
        ST_COEF_B = 9'b000100000,
        ST_MUL    = 9'b001000000,
        ST_ACC    = 9'b010000000,
        ST_OUT    = 9'b100000000
    } chp_state_t;

    typedef struct packed {
        logic              load;
        logic              first;
        logic              prep;
        logic              div_step;
        logic              phase_step;
        logic              coef_a;
        logic              coef_b;
        logic              mul;
        logic              acc;
        logic [COMP_W-1:0] comp;
    } chp_cmd_t;

    // Quarter-wave sine, 17 points pi/32 apart, Q1.16.
    function automatic logic [16:0] quarter_sine(input logic [4:0] idx);
        logic [16:0] v;
        begin
            unique case (idx)
                5'd0:  v = 17'd0;
                5'd1:  v = 17'd6424;
                5'd2:  v = 17'd12785;
                5'd3:  v = 17'd19024;
                5'd4:  v = 17'd25080;
                5'd5:  v = 17'd30893;
                5'd6:  v = 17'd36410;
                5'd7:  v = 17'd41576;
                5'd8:  v = 17'd46341;
                5'd9:  v = 17'd50660;
                5'd10: v = 17'd54491;
                5'd11: v = 17'd57798;
                5'd12: v = 17'd60547;
                5'd13: v = 17'd62714;
                5'd14: v = 17'd64277;
                5'd15: v = 17'd65220;
                default: v = 17'd65536;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/chp_ifs.sv @@
// Handshake channel interfaces: sample input, component output, register writes.
// Depends on chp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface chp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [chp_pkg::SAMPLE_W-1:0] sample;
    logic signed [chp_pkg::WARP_W-1:0]   warp;
    modport source (output valid, output sample, output warp, input ready);
    modport sink (input valid, input sample, input warp, output ready);
endinterface

interface chp_out_if;
    logic                               valid;
    logic                               ready;
    logic [chp_pkg::COMP_W-1:0]         component_index;
    logic signed [chp_pkg::VALUE_W-1:0] component_value;
    logic                               last;
    modport source (output valid, output component_index, output component_value,
                    output last, input ready);
    modport sink (input valid, input component_index, input component_value,
                  input last, output ready);
endinterface

interface chp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [chp_pkg::CFG_IDX_W-1:0]     index;
    logic [chp_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/chp_datapath.sv @@
// Arithmetic of the projection: warp quantization, phase divider, sine
// interpolation, multiply-accumulate and the accumulator file. Uses chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chp_datapath #(
    parameter int CH_W       = 7,
    parameter int WARP_STEPS = 3600,
    parameter int WS_W       = 12,
    parameter int D_W        = 19,
    parameter int M_W        = 35
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire chp_pkg::chp_cmd_t              cmd,
    input  wire [CH_W-1:0]                      n,
    input  wire [CH_W-1:0]                      mag,
    input  wire                                 neg,
    input  wire signed [chp_pkg::SAMPLE_W-1:0]  sample,
    input  wire signed [chp_pkg::WARP_W-1:0]    warp,
    output logic signed [chp_pkg::VALUE_W-1:0]  value
);

    localparam logic [WS_W-1:0] WS_M1 = WS_W'(WARP_STEPS - 1);
    localparam int WQ_W = 18 + WS_W;

    logic [WS_W-1:0]                    ws_reg;
    logic signed [chp_pkg::SAMPLE_W-1:0] sample_reg;
    logic [CH_W-1:0]                    mag_reg;
    logic                               neg_reg;
    logic                               first_reg;

    logic [D_W-1:0]  d_reg;
    logic [M_W-1:0]  num_reg;
    logic [D_W-1:0]  rem_reg;
    logic [15:0]     quo_reg;
    logic [D_W-1:0]  r_reg;
    logic [15:0]     q_reg;

    logic [16:0]     a_reg;
    logic [22:0]     frac_prod_reg;
    logic            sat_reg;
    logic            cneg_reg;
    logic signed [chp_pkg::COEF_W-1:0] coef_reg;
    logic signed [chp_pkg::SAMPLE_W+chp_pkg::COEF_W-1:0] prod_reg;
    logic signed [chp_pkg::ACC_W-1:0] acc_reg [chp_pkg::NUM_ACC];

    // warp quantization
    logic [16:0]     w_c;
    logic [WQ_W-1:0] wq;
    always_comb
    begin
        if (warp[chp_pkg::WARP_W-1])
            w_c = 17'd0;
        else if (warp > chp_pkg::WARP_W'(signed'({1'b0, chp_pkg::Q16_ONE})))
            w_c = chp_pkg::Q16_ONE;
        else
            w_c = warp[16:0];
        wq = WQ_W'(w_c) * WQ_W'(WS_M1) + WQ_W'(32768);
    end

    logic [D_W-1:0]   d_next;
    logic [M_W-1:0]   m_next;
    assign d_next = D_W'(n) * D_W'(WS_M1);
    assign m_next = {(M_W-16)'(mag_reg) * (M_W-16)'(ws_reg), 16'd0};

    // restoring divider step
    logic [D_W:0]   div_t;
    logic           div_ge;
    assign div_t  = {rem_reg, num_reg[M_W-1]};
    assign div_ge = div_t >= {1'b0, d_reg};

    // phase advance by one order
    logic [D_W:0]   r_sum;
    logic           r_ge;
    assign r_sum = {1'b0, r_reg} + {1'b0, rem_reg};
    assign r_ge  = r_sum >= {1'b0, d_reg};

    // sine lookup
    logic [15:0] ph;
    logic [14:0] x;
    logic [4:0]  seg;
    logic [16:0] ta;
    logic [16:0] tb;
    logic [16:0] tdiff;
    always_comb
    begin
        ph    = cmd.comp[0] ? q_reg : q_reg + chp_pkg::QUARTER_TURN;
        x     = ph[14] ? 15'd16384 - {1'b0, ph[13:0]} : {1'b0, ph[13:0]};
        seg   = x[14:10];
        ta    = chp_pkg::quarter_sine(seg);
        tb    = chp_pkg::quarter_sine(seg + 5'd1);
        tdiff = tb - ta;
    end

    logic [22:0] frac_rnd;
    logic [16:0] cmag;
    always_comb
    begin
        frac_rnd = frac_prod_reg + 23'd512;
        cmag = sat_reg ? chp_pkg::Q16_ONE : a_reg + 17'(frac_rnd >> 10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= '0;
        end
        else if (cmd.load && cmd.first)
        begin
            ws_reg <= wq[15+WS_W:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            mag_reg    <= mag;
            neg_reg    <= neg;
            first_reg  <= cmd.first;
        end
        if (cmd.prep)
        begin
            d_reg   <= d_next;
            num_reg <= m_next;
            rem_reg <= '0;
            quo_reg <= '0;
            r_reg   <= d_next >> 1;
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= {num_reg[M_W-2:0], 1'b0};
            rem_reg <= div_ge ? D_W'(div_t - {1'b0, d_reg}) : div_t[D_W-1:0];
            quo_reg <= {quo_reg[14:0], div_ge};
        end
        if (cmd.phase_step)
        begin
            r_reg <= r_ge ? D_W'(r_sum - {1'b0, d_reg}) : r_sum[D_W-1:0];
            q_reg <= q_reg + quo_reg + {15'd0, r_ge};
        end
        if (cmd.coef_a)
        begin
            a_reg         <= ta;
            frac_prod_reg <= tdiff[12:0] * x[9:0];
            sat_reg       <= (cmd.comp == '0) || seg[4];
            cneg_reg      <= (cmd.comp != '0) && (ph[15] ^ (cmd.comp[0] && neg_reg));
        end
        if (cmd.coef_b)
        begin
            coef_reg <= cneg_reg ? -signed'({1'b0, cmag}) : signed'({1'b0, cmag});
        end
        if (cmd.mul)
        begin
            prod_reg <= sample_reg * coef_reg;
        end
        if (cmd.acc)
        begin
            // first channel overwrites, which also restarts the frame
            if (first_reg)
                acc_reg[cmd.comp] <= chp_pkg::ACC_W'(prod_reg);
            else
                acc_reg[cmd.comp] <= acc_reg[cmd.comp] + chp_pkg::ACC_W'(prod_reg);
        end
    end

    assign value = acc_reg[cmd.comp][chp_pkg::ACC_W-1:16];

endmodule

`default_nettype wire

@@ hdl/chp_controller.sv @@
// Sequencer for the projection: configuration registers, frame position,
// division and per-component schedule. Uses chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chp_controller #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_ORDER    = 7,
    parameter int CH_W         = 7,
    parameter int M_W          = 35
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic                              out_last,
    input  wire                               cfg_valid,
    input  wire [chp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [chp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output chp_pkg::chp_cmd_t                 cmd,
    output logic [CH_W-1:0]                   n,
    output logic [CH_W-1:0]                   mag,
    output logic                              neg
);

    localparam int ORD_CAP = (MAX_ORDER > 7) ? 7 : MAX_ORDER;
    localparam int DC_W = $clog2(M_W + 1);

    chp_pkg::chp_state_t state_reg, state_next;
    logic [chp_pkg::CCOUNT_W-1:0] ccount_reg;
    logic [chp_pkg::ORDER_W-1:0]  order_reg;
    logic [CH_W-1:0]              pos_reg, pos_next;
    logic [chp_pkg::COMP_W-1:0]   comp_reg, comp_next;
    logic [DC_W-1:0]              dcnt_reg, dcnt_next;

    logic [chp_pkg::ORDER_W-1:0]  order;
    logic [chp_pkg::COMP_W-1:0]   comp_max;
    logic                         accept;
    logic                         last_ch;
    logic                         cfg_hit;

    always_comb
    begin
        if (ccount_reg == '0)
            n = CH_W'(1);
        else if (32'(ccount_reg) > MAX_CHANNELS)
            n = CH_W'(MAX_CHANNELS);
        else
            n = CH_W'(ccount_reg);
        if (order_reg == '0)
            order = chp_pkg::ORDER_W'(1);
        else if (32'(order_reg) > ORD_CAP)
            order = chp_pkg::ORDER_W'(ORD_CAP);
        else
            order = order_reg;
        comp_max = {order, 1'b0};
        if ({pos_reg, 1'b0} > {1'b0, n})
        begin
            mag = n - pos_reg;
            neg = 1'b1;
        end
        else
        begin
            mag = pos_reg;
            neg = 1'b0;
        end
    end

    assign in_ready  = state_reg == chp_pkg::ST_IDLE;
    assign accept    = in_valid && in_ready;
    assign last_ch   = (pos_reg + CH_W'(1)) >= n;
    assign out_valid = state_reg == chp_pkg::ST_OUT;
    assign out_last  = comp_reg == comp_max;
    assign cfg_hit   = cfg_valid && ((cfg_index == chp_pkg::REG_CHANNEL_COUNT) ||
                                     (cfg_index == chp_pkg::REG_HARMONIC_ORDER));

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        comp_next  = comp_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        cmd.first  = pos_reg == '0;
        unique case (state_reg)
            chp_pkg::ST_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                    state_next = chp_pkg::ST_PREP;
            end
            chp_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                dcnt_next  = '0;
                comp_next  = '0;
                state_next = chp_pkg::ST_DIV;
            end
            chp_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + DC_W'(1);
                if (dcnt_reg == DC_W'(M_W - 1))
                    state_next = chp_pkg::ST_COEF_A;
            end
            chp_pkg::ST_PHASE:
            begin
                cmd.phase_step = 1'b1;
                state_next     = chp_pkg::ST_COEF_A;
            end
            chp_pkg::ST_COEF_A:
            begin
                cmd.coef_a = 1'b1;
                state_next = chp_pkg::ST_COEF_B;
            end
            chp_pkg::ST_COEF_B:
            begin
                cmd.coef_b = 1'b1;
                state_next = chp_pkg::ST_MUL;
            end
            chp_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = chp_pkg::ST_ACC;
            end
            chp_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (comp_reg == comp_max)
                begin
                    comp_next = '0;
                    if (last_ch)
                        state_next = chp_pkg::ST_OUT;
                    else
                    begin
                        pos_next   = pos_reg + CH_W'(1);
                        state_next = chp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    comp_next = comp_reg + chp_pkg::COMP_W'(1);
                    // a sine component opens a new order: advance the phase
                    state_next = comp_reg[0] ? chp_pkg::ST_COEF_A : chp_pkg::ST_PHASE;
                end
            end
            chp_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    if (comp_reg == comp_max)
                    begin
                        comp_next  = '0;
                        pos_next   = '0;
                        state_next = chp_pkg::ST_IDLE;
                    end
                    else
                        comp_next = comp_reg + chp_pkg::COMP_W'(1);
                end
            end
            default:
            begin
                state_next = chp_pkg::ST_IDLE;
            end
        endcase
        if (cfg_hit)
            pos_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= chp_pkg::ST_IDLE;
            ccount_reg <= chp_pkg::CCOUNT_W'(16);
            order_reg  <= chp_pkg::ORDER_W'(7);
            pos_reg    <= '0;
            comp_reg   <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            comp_reg  <= comp_next;
            dcnt_reg  <= dcnt_next;
            if (cfg_valid && (cfg_index == chp_pkg::REG_CHANNEL_COUNT))
                ccount_reg <= cfg_data;
            if (cfg_valid && (cfg_index == chp_pkg::REG_HARMONIC_ORDER))
                order_reg <= cfg_data[chp_pkg::ORDER_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hdl/circular_harmonic_projection.sv @@
// Circular harmonic projection of equally spaced channel samples.
// Uses chp_pkg, chp_ifs, chp_controller and chp_datapath.
//
// Usage: send one frame of channel_count transactions on samples, one
// sample per channel in order; warp is read on the first channel only.
// After the last channel, components carries 2*order+1 transactions,
// index 0 up to 2*order, with last set on the final one.
// The phase numerator is M bits wide (35 at default parameters); a
// one-bit-a-cycle phase divider works through it, and a single shared
// multiply-accumulate serves every component. samples is held not ready
// while a transaction is in work and while the component transactions of a
// frame are offered.
// A stalled receiver holds the current component; nothing is dropped.
// cfg is always ready; a write to either register restarts the frame.
// Reset: channel_count 16, harmonic_order 7, frame position zero, warp 0.
// No clearing pass: the first channel of a frame overwrites the sums.
`timescale 1ns / 1ps
`default_nettype none

module circular_harmonic_projection #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_ORDER    = 7,
    parameter int WARP_STEPS   = 3600
) (
    input  wire        clk,
    input  wire        rst_n,
    chp_in_if.sink     samples,
    chp_out_if.source  components,
    chp_cfg_if.sink    cfg
);

    localparam int CH_W = $clog2(MAX_CHANNELS + 1);
    localparam int WS_W = $clog2(WARP_STEPS);
    localparam int D_W  = CH_W + WS_W;
    localparam int M_W  = CH_W + WS_W + 16;

    chp_pkg::chp_cmd_t cmd;
    logic [CH_W-1:0]   n;
    logic [CH_W-1:0]   mag;
    logic              neg;

    assign cfg.ready = 1'b1;

    chp_controller #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_ORDER    (MAX_ORDER),
        .CH_W         (CH_W),
        .M_W          (M_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (components.valid),
        .out_ready (components.ready),
        .out_last  (components.last),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .n         (n),
        .mag       (mag),
        .neg       (neg)
    );

    chp_datapath #(
        .CH_W       (CH_W),
        .WARP_STEPS (WARP_STEPS),
        .WS_W       (WS_W),
        .D_W        (D_W),
        .M_W        (M_W)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .n      (n),
        .mag    (mag),
        .neg    (neg),
        .sample (samples.sample),
        .warp   (samples.warp),
        .value  (components.component_value)
    );

    assign components.component_index = cmd.comp;

endmodule

`default_nettype wire

@@ bench/circular_harmonic_projection_test.sv @@
// Self-checking bench for circular_harmonic_projection: drives sample frames and
// register writes, predicts every component and compares it field by field.
// Depends on chp_pkg, chp_ifs and the block under test.
`timescale 1ns / 1ps

module circular_harmonic_projection_test;

    localparam int PHASE_STEPS = 3599;
    localparam int IDLE_WAIT   = 300;
    localparam int LONG_HOLD   = 3000;
    localparam int RANDOM_ITEMS = 470;
    localparam int QSIN [17] = '{
        0, 6424, 12785, 19024, 25080, 30893, 36410, 41576, 46341,
        50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536
    };

    typedef struct {
        logic [chp_pkg::COMP_W-1:0]         idx;
        logic signed [chp_pkg::VALUE_W-1:0] val;
        logic                               last;
    } component_t;

    typedef struct {
        logic signed [chp_pkg::SAMPLE_W-1:0] sample;
        logic signed [chp_pkg::WARP_W-1:0]   warp;
    } frame_row_t;

    logic clk;
    logic rst_n;
    int   errors = 0;
    int   items_sent = 0;
    int   burst_left = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   stall_phase = 0;

    component_t component_q[$];

    // predicted block state
    longint      harm_sum [chp_pkg::NUM_ACC];
    int unsigned frame_pos;
    int unsigned warp_idx;
    logic [6:0]  chan_reg;
    logic [2:0]  order_reg;

    chp_in_if  samples_ch ();
    chp_out_if comps_ch ();
    chp_cfg_if cfg_ch ();

    circular_harmonic_projection DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples_ch.sink),
        .components (comps_ch.source),
        .cfg        (cfg_ch.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int quarter_wave(input int unsigned x);
        int unsigned seg;
        int unsigned frac;
        begin
            seg  = x >> 10;
            frac = x & 32'h3FF;
            if (seg >= 16)
                return QSIN[16];
            return QSIN[seg] + int'(((QSIN[seg+1] - QSIN[seg]) * frac + 512) >> 10);
        end
    endfunction

    function automatic int turn_sine(input int unsigned ph);
        int unsigned pos;
        begin
            pos = ph & 32'h3FFF;
            case ((ph >> 14) & 3)
                0: return quarter_wave(pos);
                1: return quarter_wave(16384 - pos);
                2: return -quarter_wave(pos);
                default: return -quarter_wave(16384 - pos);
            endcase
        end
    endfunction

    function automatic int unsigned frame_len();
        int unsigned n;
        begin
            n = chan_reg;
            if (n < 1) n = 1;
            if (n > 64) n = 64;
            return n;
        end
    endfunction

    function automatic int unsigned order_len();
        return (order_reg < 1) ? 1 : order_reg;
    endfunction

    task automatic restart_sums();
        for (int i = 0; i < chp_pkg::NUM_ACC; i++)
            harm_sum[i] = 0;
        frame_pos = 0;
    endtask

    // Accumulate one channel; at frame end queue the components if emit is set.
    task automatic project_channel(input logic signed [chp_pkg::SAMPLE_W-1:0] s,
                                   input logic signed [chp_pkg::WARP_W-1:0] w,
                                   input bit emit);
        int unsigned n;
        int unsigned ord;
        int unsigned mag;
        int unsigned ph;
        longint      wv;
        longint unsigned den;
        longint unsigned num;
        bit          neg;
        int          sc;
        int          cc;
        longint      sv;
        component_t  c;
        begin
            n   = frame_len();
            ord = order_len();
            sv  = s;
            if (frame_pos == 0)
            begin
                wv = w;
                if (wv < 0) wv = 0;
                if (wv > 65536) wv = 65536;
                warp_idx = int'((wv * PHASE_STEPS + 32768) >> 16);
            end
            if (2 * frame_pos > n)
            begin
                mag = n - frame_pos;
                neg = 1'b1;
            end
            else
            begin
                mag = frame_pos;
                neg = 1'b0;
            end
            harm_sum[0] += sv * 65536;
            den = longint'(n) * PHASE_STEPS;
            for (int k = 1; k <= ord; k++)
            begin
                num = longint'(k) * mag * warp_idx * 65536 + den / 2;
                ph  = int'((num / den) & 16'hFFFF);
                sc  = turn_sine(ph);
                cc  = turn_sine((ph + 16384) & 16'hFFFF);
                if (neg) sc = -sc;
                harm_sum[2*k-1] += sv * sc;
                harm_sum[2*k]   += sv * cc;
            end
            if (frame_pos + 1 >= n)
            begin
                if (emit)
                    for (int i = 0; i < 2 * ord + 1; i++)
                    begin
                        c.idx  = i;
                        c.val  = harm_sum[i] >>> 16;
                        c.last = (i == 2 * ord);
                        component_q.push_back(c);
                    end
                restart_sums();
            end
            else
                frame_pos = (frame_pos + 1) & 6'h3F;
        end
    endtask

    // Offer one sample transaction; bursts end in a random gap.
    task automatic send_sample(input logic signed [chp_pkg::SAMPLE_W-1:0] s,
                               input logic signed [chp_pkg::WARP_W-1:0] w,
                               input bit emit);
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        samples_ch.warp   <= w;
        do @(posedge clk); while (!samples_ch.ready);
        project_channel(s, w, emit);
        items_sent++;
        if (--burst_left <= 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    // Drop valid and let the block finish every pending component.
    task automatic wait_idle();
        samples_ch.valid <= 1'b0;
        wait (component_q.size() == 0);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [chp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [chp_pkg::CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == chp_pkg::REG_CHANNEL_COUNT)
        begin
            chan_reg = data;
            restart_sums();
        end
        else if (idx == chp_pkg::REG_HARMONIC_ORDER)
        begin
            order_reg = data[2:0];
            restart_sums();
        end
    endtask

    function automatic logic signed [chp_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return -24'sd8388608;
            1: return 24'sd8388607;
            2: return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [chp_pkg::WARP_W-1:0] pick_warp();
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return 18'sd0;
            2: return 18'sd65536;
            3: return $urandom_range(65537, 131071);
            4: return -($urandom_range(1, 131072));
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [chp_pkg::CFG_DATA_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd64;
            2: return $urandom_range(65, 127);
            3: return $urandom_range(9, 63);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // Receiver: changing stall pattern plus a long hold on request.
    always @(posedge clk)
    begin
        if (comps_ch.valid && comps_ch.ready)
        begin
            if (component_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected component idx %0d value %0d", $time,
                         comps_ch.component_index, comps_ch.component_value);
            end
            else
            begin
                component_t e;
                e = component_q.pop_front();
                if (e.idx !== comps_ch.component_index || e.val !== comps_ch.component_value
                    || e.last !== comps_ch.last)
                begin
                    errors++;
                    $display("%0t: expected idx %0d value %0d last %0b, got %0d %0d %0b",
                             $time, e.idx, e.val, e.last, comps_ch.component_index,
                             comps_ch.component_value, comps_ch.last);
                end
            end
        end
        stall_phase++;
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            comps_ch.ready <= 1'b0;
        end
        else
            case ((stall_phase / 57) % 3)
                0: comps_ch.ready <= 1'b1;
                1: comps_ch.ready <= stall_phase[0];
                default: comps_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
    end

    frame_row_t reset_frame [16] = '{
        '{24'sd8388607, 18'sd65536}, '{-24'sd8388608, 18'sd0},
        '{24'sd1, 18'sd0}, '{-24'sd1, 18'sd0}, '{24'sd1000000, 18'sd0},
        '{24'sd0, 18'sd0}, '{24'sd8388607, 18'sd0}, '{24'sd8388607, 18'sd0},
        '{-24'sd8388608, 18'sd0}, '{24'sd12345, 18'sd0}, '{-24'sd777, 18'sd0},
        '{24'sd4194304, 18'sd0}, '{24'sd2, 18'sd0}, '{-24'sd4194304, 18'sd0},
        '{24'sd8388607, 18'sd0}, '{24'sd99, 18'sd0}
    };
    // single channel, order one: omni and cosine equal the sample, sine is zero
    frame_row_t single_rows [8] = '{
        '{24'sd8388607, 18'sd131071}, '{-24'sd8388608, -18'sd131072},
        '{24'sd0, 18'sd65536}, '{-24'sd1, 18'sd65537}, '{24'sd1, -18'sd1},
        '{24'sd5592405, 18'sd43690}, '{-24'sd5592406, -18'sd43691}, '{24'sd255, 18'sd0}
    };

    initial
    begin
        component_t c;
        int unsigned n;
        rst_n = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.sample = '0;
        samples_ch.warp = '0;
        comps_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        restart_sums();
        warp_idx  = 0;
        chan_reg  = 7'd16;
        order_reg = 3'd7;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a full frame at the reset setting, full warp
        foreach (reset_frame[i])
            send_sample(reset_frame[i].sample, reset_frame[i].warp, 1'b1);
        write_reg(chp_pkg::REG_CHANNEL_COUNT, 7'd1);
        write_reg(chp_pkg::REG_HARMONIC_ORDER, 7'd1);
        foreach (single_rows[i])
        begin
            c = '{4'd0, 32'(single_rows[i].sample), 1'b0};
            component_q.push_back(c);
            c = '{4'd1, 32'sd0, 1'b0};
            component_q.push_back(c);
            c = '{4'd2, 32'(single_rows[i].sample), 1'b1};
            component_q.push_back(c);
            send_sample(single_rows[i].sample, single_rows[i].warp, 1'b0);
        end

        // random phases
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1))
            begin
                write_reg(chp_pkg::REG_CHANNEL_COUNT, pick_count());
                write_reg(chp_pkg::REG_HARMONIC_ORDER, $urandom);
            end
            else
            begin
                write_reg(chp_pkg::REG_HARMONIC_ORDER, $urandom);
                write_reg(chp_pkg::REG_CHANNEL_COUNT, pick_count());
            end
            if (items_sent > 200 && hold_req == 0)
            begin
                // fill the block while the receiver holds off
                write_reg(chp_pkg::REG_CHANNEL_COUNT, 7'd1);
                write_reg(chp_pkg::REG_HARMONIC_ORDER, 7'd7);
                hold_req++;
                repeat (6) send_sample(pick_sample(), pick_warp(), 1'b1);
            end
            n = frame_len();
            repeat ($urandom_range(1, (n > 16) ? 2 : 5))
            begin
                for (int i = 0; i < n; i++)
                    send_sample(pick_sample(), (i == 0) ? pick_warp() : $urandom, 1'b1);
                if ($urandom_range(0, 4) == 0)
                    wait_idle();
            end
            case ($urandom_range(0, 5))
                0:
                begin
                    // broken frame, cut off by a register write
                    if (n > 1)
                        repeat ($urandom_range(1, n - 1))
                            send_sample(pick_sample(), pick_warp(), 1'b1);
                end
                1:
                begin
                    // unknown index mid-frame: the frame goes on
                    if (n > 1)
                    begin
                        send_sample(pick_sample(), pick_warp(), 1'b1);
                        write_reg(2'd2 + $urandom_range(0, 1), $urandom);
                        for (int i = 1; i < n; i++)
                            send_sample(pick_sample(), $urandom, 1'b1);
                    end
                end
                default: ;
            endcase
        end

        samples_ch.valid <= 1'b0;
        wait (component_q.size() == 0);
        repeat (IDLE_WAIT) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
